>>> src/bvnf_pkg.sv
// Shared types, class codes and rule codes for the binary voxel neighbor rule filter.
package bvnf_pkg;

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 3;
    localparam int RULE_W      = 3;
    localparam int CLASS_W     = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [RULE_W-1:0]  rule_t;
    typedef logic [CLASS_W-1:0] class_t;

    // Row bit positions
    localparam int BIT_L = 2;
    localparam int BIT_C = 1;
    localparam int BIT_R = 0;

    // Plane classes
    localparam class_t CLS_NONE      = 8'h00;
    localparam class_t CLS_BOTH      = 8'h01;
    localparam class_t CLS_VERT      = 8'h02;
    localparam class_t CLS_HORZ      = 8'h03;
    localparam class_t CLS_END       = 8'h10;
    localparam class_t CLS_TWO       = 8'h20;
    localparam class_t CLS_THREE_ONE = 8'h31;
    localparam class_t CLS_THREE_TWO = 8'h32;
    localparam class_t CLS_FOUR      = 8'h40;
    localparam class_t CLS_FIVE      = 8'h50;

    // Rules
    localparam rule_t RULE_NONE       = 3'd0;
    localparam rule_t RULE_SLICE_BOTH = 3'd1;
    localparam rule_t RULE_MARK_VERT  = 3'd2;
    localparam rule_t RULE_ROW_VERT   = 3'd3;
    localparam rule_t RULE_MARK_OTHER = 3'd4;
    localparam rule_t RULE_DEFAULT    = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MARK_VERT  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MARK_OTHER = 1'd1;

    typedef struct packed {
        logic n11;
        logic n12;
        logic n13;
        logic n21;
        logic n23;
        logic n31;
        logic n32;
        logic n33;
    } ring_t;

    typedef struct packed {
        row_t s1_top_row;
        row_t s1_mid_row;
        row_t s1_bot_row;
        row_t s2_top_row;
        row_t s2_mid_row;
        row_t s2_bot_row;
        row_t s3_top_row;
        row_t s3_mid_row;
        row_t s3_bot_row;
        pix_t center_value;
        logic on_border;
    } item_t;

    typedef struct packed {
        pix_t  pixel_out;
        rule_t rule_fired;
    } result_t;

endpackage

>>> src/bvnf_in_if.sv
// Input channel carrying one voxel neighborhood per transaction.
interface bvnf_in_if;
    import bvnf_pkg::*;

    logic valid;
    logic ready;
    row_t s1_top_row;
    row_t s1_mid_row;
    row_t s1_bot_row;
    row_t s2_top_row;
    row_t s2_mid_row;
    row_t s2_bot_row;
    row_t s3_top_row;
    row_t s3_mid_row;
    row_t s3_bot_row;
    pix_t center_value;
    logic on_border;

    modport source (
        output valid,
        input  ready,
        output s1_top_row, s1_mid_row, s1_bot_row,
        output s2_top_row, s2_mid_row, s2_bot_row,
        output s3_top_row, s3_mid_row, s3_bot_row,
        output center_value, on_border
    );

    modport sink (
        input  valid,
        output ready,
        input  s1_top_row, s1_mid_row, s1_bot_row,
        input  s2_top_row, s2_mid_row, s2_bot_row,
        input  s3_top_row, s3_mid_row, s3_bot_row,
        input  center_value, on_border
    );
endinterface

>>> src/bvnf_out_if.sv
// Output channel carrying one filtered pixel per transaction.
interface bvnf_out_if;
    import bvnf_pkg::*;

    logic  valid;
    logic  ready;
    pix_t  pixel_out;
    rule_t rule_fired;

    modport source (
        output valid,
        input  ready,
        output pixel_out, rule_fired
    );

    modport sink (
        input  valid,
        output ready,
        input  pixel_out, rule_fired
    );
endinterface

>>> src/bvnf_ring_class.sv
// Classifies one plane from its eight ring neighbors.
module bvnf_ring_class (
    input  bvnf_pkg::ring_t  ring,
    output bvnf_pkg::class_t cls
);
    import bvnf_pkg::*;

    logic       vert;
    logic       horz;
    logic [3:0] count;
    logic [2:0] corners;
    logic [3:0] changes;

    assign vert = ring.n12 & ring.n32;
    assign horz = ring.n21 & ring.n23;

    assign count = 4'(ring.n11) + 4'(ring.n12) + 4'(ring.n13) + 4'(ring.n21)
                 + 4'(ring.n23) + 4'(ring.n31) + 4'(ring.n32) + 4'(ring.n33);

    assign corners = 3'(ring.n11) + 3'(ring.n13) + 3'(ring.n31) + 3'(ring.n33);

    // Walk around the ring clockwise
    assign changes = 4'(ring.n11 ^ ring.n21) + 4'(ring.n12 ^ ring.n11)
                   + 4'(ring.n13 ^ ring.n12) + 4'(ring.n23 ^ ring.n13)
                   + 4'(ring.n33 ^ ring.n23) + 4'(ring.n32 ^ ring.n33)
                   + 4'(ring.n31 ^ ring.n32) + 4'(ring.n21 ^ ring.n31);

    always_comb
    begin
        if (vert && horz)
            cls = CLS_BOTH;
        else if (vert)
            cls = CLS_VERT;
        else if (horz)
            cls = CLS_HORZ;
        else if (count == 4'd1 && corners == 3'd1)
            cls = CLS_END;
        else if (count == 4'd2 && changes == 4'd2)
            cls = CLS_TWO;
        else if (count == 4'd3 && changes == 4'd2 && corners == 3'd1)
            cls = CLS_THREE_ONE;
        else if (count == 4'd3 && changes == 4'd2 && corners == 3'd2)
            cls = CLS_THREE_TWO;
        else if (count == 4'd4 && changes == 4'd2)
            cls = CLS_FOUR;
        else if (count == 4'd5 && changes == 4'd2)
            cls = CLS_FIVE;
        else
            cls = CLS_NONE;
    end

endmodule

>>> src/bvnf_eval.sv
// Builds the three plane rings, classifies them and applies the ordered rules.
module bvnf_eval (
    input  bvnf_pkg::item_t   item,
    input  bvnf_pkg::pix_t    mark_vert,
    input  bvnf_pkg::pix_t    mark_other,
    output bvnf_pkg::result_t result
);
    import bvnf_pkg::*;

    ring_t  ring_s;
    ring_t  ring_r;
    ring_t  ring_c;
    class_t cls_s;
    class_t cls_r;
    class_t cls_c;
    class_t cls_max;

    // Slice plane
    assign ring_s = '{
        n11: item.s2_top_row[BIT_L], n12: item.s2_top_row[BIT_C], n13: item.s2_top_row[BIT_R],
        n21: item.s2_mid_row[BIT_L], n23: item.s2_mid_row[BIT_R],
        n31: item.s2_bot_row[BIT_L], n32: item.s2_bot_row[BIT_C], n33: item.s2_bot_row[BIT_R]
    };

    // Row plane, across slices
    assign ring_r = '{
        n11: item.s1_mid_row[BIT_L], n12: item.s1_mid_row[BIT_C], n13: item.s1_mid_row[BIT_R],
        n21: item.s2_mid_row[BIT_L], n23: item.s2_mid_row[BIT_R],
        n31: item.s3_mid_row[BIT_L], n32: item.s3_mid_row[BIT_C], n33: item.s3_mid_row[BIT_R]
    };

    // Column plane, across slices
    assign ring_c = '{
        n11: item.s1_top_row[BIT_C], n12: item.s1_mid_row[BIT_C], n13: item.s1_bot_row[BIT_C],
        n21: item.s2_top_row[BIT_C], n23: item.s2_bot_row[BIT_C],
        n31: item.s3_top_row[BIT_C], n32: item.s3_mid_row[BIT_C], n33: item.s3_bot_row[BIT_C]
    };

    bvnf_ring_class u_class_s (.ring(ring_s), .cls(cls_s));
    bvnf_ring_class u_class_r (.ring(ring_r), .cls(cls_r));
    bvnf_ring_class u_class_c (.ring(ring_c), .cls(cls_c));

    assign cls_max = (cls_r > cls_c) ? cls_r : cls_c;

    always_comb
    begin
        result.pixel_out  = item.center_value;
        result.rule_fired = RULE_NONE;
        if (!item.on_border && item.center_value != '0)
        begin
            if (cls_s == CLS_BOTH)
                result.rule_fired = RULE_SLICE_BOTH;
            else if (cls_r == CLS_VERT && cls_s >= CLS_FOUR)
            begin
                result.rule_fired = RULE_MARK_VERT;
                result.pixel_out  = mark_vert;
            end
            else if (cls_r == CLS_VERT)
                result.rule_fired = RULE_ROW_VERT;
            else if (cls_max >= CLS_FOUR)
            begin
                result.rule_fired = RULE_MARK_OTHER;
                result.pixel_out  = mark_other;
            end
            else
                result.rule_fired = RULE_DEFAULT;
        end
    end

endmodule

>>> src/binary_voxel_neighbor_rule_filter_core.sv
// Top level of the binary voxel neighbor rule filter: input register, rule logic, result register.
//
// in_port takes one voxel neighborhood per transaction (valid/ready): nine 3-bit rows
// from the previous, current and next slice, the center pixel value and a border flag.
// out_port delivers one result per input: the filtered pixel and the rule that decided
// (0 when the pixel is on the border or zero, else 1 to 5).
// Two mark values are set through the write port (cfg_we, cfg_index, cfg_data):
// index 0 is the vertical-plane mark, index 1 the row/column mark. Write them only
// while no transaction is in flight.
// An accepted transaction is held in the input register and then in the result register
// before it is valid on out_port. Throughput is one item per cycle while out_port.ready
// stays high: the input register and the result register each advance whenever the stage
// after them is empty or being drained, so a new item enters every cycle.
// When the receiver stalls, the result register holds and the input register fills;
// in_port.ready drops only once both are full, and no item is lost or repeated.
// Reset clears both valid flags and sets both mark values to zero.
module binary_voxel_neighbor_rule_filter_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    bvnf_in_if.sink                              in_port,
    bvnf_out_if.source                           out_port,
    input  logic                                 cfg_we,
    input  logic [bvnf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bvnf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bvnf_pkg::*;

    pix_t    mark_vert_reg;
    pix_t    mark_other_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;
    result_t result_next;
    item_t   item_next;
    logic    result_load;
    logic    item_load;

    assign result_load   = !result_valid_reg || out_port.ready;
    assign in_port.ready = !item_valid_reg || result_load;
    assign item_load     = in_port.valid && in_port.ready;

    assign item_next = '{
        s1_top_row:   in_port.s1_top_row,
        s1_mid_row:   in_port.s1_mid_row,
        s1_bot_row:   in_port.s1_bot_row,
        s2_top_row:   in_port.s2_top_row,
        s2_mid_row:   in_port.s2_mid_row,
        s2_bot_row:   in_port.s2_bot_row,
        s3_top_row:   in_port.s3_top_row,
        s3_mid_row:   in_port.s3_mid_row,
        s3_bot_row:   in_port.s3_bot_row,
        center_value: in_port.center_value,
        on_border:    in_port.on_border
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_vert_reg  <= '0;
            mark_other_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MARK_VERT:  mark_vert_reg  <= cfg_data;
                REG_MARK_OTHER: mark_other_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_port.ready)
            item_valid_reg <= in_port.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
            item_reg <= item_next;
    end

    bvnf_eval u_eval (
        .item       (item_reg),
        .mark_vert  (mark_vert_reg),
        .mark_other (mark_other_reg),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (result_load)
            result_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (result_load && item_valid_reg)
            result_reg <= result_next;
    end

    assign out_port.valid      = result_valid_reg;
    assign out_port.pixel_out  = result_reg.pixel_out;
    assign out_port.rule_fired = result_reg.rule_fired;

    a_mark_vert: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.rule_fired == RULE_MARK_VERT
            |-> result_reg.pixel_out == mark_vert_reg)
        else $error("vertical mark rule without vertical mark value");

    a_mark_other: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.rule_fired == RULE_MARK_OTHER
            |-> result_reg.pixel_out == mark_other_reg)
        else $error("other mark rule without other mark value");

    a_rule_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> result_reg.rule_fired <= RULE_DEFAULT)
        else $error("rule code out of range");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_port.valid && in_port.ready |=> item_valid_reg)
        else $error("accepted transaction not captured");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && result_valid_reg && !out_port.ready |=> item_valid_reg)
        else $error("pending item dropped during stall");

endmodule
